@@ design/cplc_pkg.sv @@
// ----------------------------------------------------------------------------
// cplc_pkg
// Shared types and constants for the convex polygon line clipper.
// ----------------------------------------------------------------------------
package cplc_pkg;

   // Sequencer states of the clip engine
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT,
      ST_SUM,
      ST_EVAL,
      ST_DIV,
      ST_LERP,
      ST_OUT
   } state_type;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_CLIP = 1'b1;

   localparam int unsigned EDGE_COUNT_BITS  = 4;
   localparam int unsigned EDGE_COUNT_RESET = 4;
   localparam int unsigned EDGE_COUNT_MIN   = 3;

   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_EDGE_COUNT = 3'd0;

endpackage

@@ design/cplc_if.sv @@
// ----------------------------------------------------------------------------
// cplc_if
// Request and response channels of the line clipper (valid/ready).
// ----------------------------------------------------------------------------
interface cplc_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [2:0]                   vertex_index;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (
      output valid, func, vertex_index, vertex_x, vertex_y,
      output start_x, start_y, end_x, end_y,
      input  ready
   );
   modport sink (
      input  valid, func, vertex_index, vertex_x, vertex_y,
      input  start_x, start_y, end_x, end_y,
      output ready
   );
endinterface

interface cplc_rsp_if #(
   parameter int COORD_BITS  = 16,
   parameter int T_FRAC_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         visible;
   logic [T_FRAC_BITS:0]         enter_t;
   logic [T_FRAC_BITS:0]         exit_t;
   logic signed [COORD_BITS-1:0] clip_start_x;
   logic signed [COORD_BITS-1:0] clip_start_y;
   logic signed [COORD_BITS-1:0] clip_end_x;
   logic signed [COORD_BITS-1:0] clip_end_y;

   modport source (
      output valid, visible, enter_t, exit_t,
      output clip_start_x, clip_start_y, clip_end_x, clip_end_y,
      input  ready
   );
   modport sink (
      input  valid, visible, enter_t, exit_t,
      input  clip_start_x, clip_start_y, clip_end_x, clip_end_y,
      output ready
   );
endinterface

@@ design/cplc_div_cell.sv @@
// ----------------------------------------------------------------------------
// cplc_div_cell
// One restoring-division cell: produces one quotient bit per pass.
// ----------------------------------------------------------------------------
module cplc_div_cell #(
   parameter int UW = 35,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [UW-1:0] in_rem,
   input  logic [UW-1:0] in_div,
   input  logic [QW-1:0] in_quo,
   output logic          out_valid,
   output logic [UW-1:0] out_rem,
   output logic [UW-1:0] out_div,
   output logic [QW-1:0] out_quo
);
   logic          valid_ff;
   logic [UW-1:0] rem_ff, rem_in, div_ff;
   logic [QW-1:0] quo_ff, quo_in;
   logic [UW-1:0] rem2;
   logic          take;

   always_comb begin
      rem2   = {in_rem[UW-2:0], 1'b0};
      take   = (rem2 >= in_div);
      rem_in = take ? (rem2 - in_div) : rem2;
      quo_in = {in_quo[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff <= rem_in;
      div_ff <= in_div;
      quo_ff <= quo_in;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quo   = quo_ff;
endmodule

@@ design/cplc_div_chain.sv @@
// ----------------------------------------------------------------------------
// cplc_div_chain
// Row of registered division cells; a fraction of QW bits leaves the last cell.
// ----------------------------------------------------------------------------
module cplc_div_chain #(
   parameter int UW = 35,
   parameter int QW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [UW-1:0] dividend,
   input  logic [UW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);
   logic          v [QW+1];
   logic [UW-1:0] r [QW+1];
   logic [UW-1:0] d [QW+1];
   logic [QW-1:0] q [QW+1];

   assign v[0] = start;
   assign r[0] = dividend;
   assign d[0] = divisor;
   assign q[0] = '0;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      cplc_div_cell #(.UW(UW), .QW(QW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v[g]),
         .in_rem    (r[g]),
         .in_div    (d[g]),
         .in_quo    (q[g]),
         .out_valid (v[g+1]),
         .out_rem   (r[g+1]),
         .out_div   (d[g+1]),
         .out_quo   (q[g+1])
      );
   end

   assign done     = v[QW];
   assign quotient = q[QW];
endmodule

@@ design/convex_polygon_line_clipper.sv @@
// ----------------------------------------------------------------------------
// convex_polygon_line_clipper
// Parametric clipping of 2D segments against a counter-clockwise convex
// polygon held in a small vertex memory.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  req     | in        | vertex load (func 0) or segment clip (func 1)
//  rsp     | out       | visibility, enter/exit t, clipped endpoints
//  csr     | in/out    | APB register edge_count at address 0
//
//  A load gives no response item.
//  A clip steps through READ, MULT, SUM and EVAL for each edge, plus DIV
//  when the edge needs a division, then LERP and OUT; a rejecting edge
//  ends the edge loop early.
//  req.ready is high only while the sequencer is idle; a waiting response
//  holds the finished clip in its last state until taken.
//  Synchronous active-high reset; the vertex memory is not cleared.
// ----------------------------------------------------------------------------
module convex_polygon_line_clipper #(
   parameter int MAX_VERTICES = 8,
   parameter int COORD_BITS   = 16,
   parameter int T_FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   cplc_req_if.sink                            req,
   cplc_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cplc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [cplc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [cplc_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import cplc_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = T_FRAC_BITS;
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int KB = $clog2(MAX_VERTICES + 1);
   localparam int KW = (KB > EDGE_COUNT_BITS) ? KB : EDGE_COUNT_BITS;
   localparam int IW = (AW > 3) ? AW : 3;
   localparam int DW = C + 1;
   localparam int MW = 2 * DW;
   localparam int PW = MW + 1;
   localparam int LW = DW + F + 2;
   localparam logic [F:0] T_ONE = (F+1)'(1) << F;

   // ---------------- configuration ----------------
   logic [EDGE_COUNT_BITS-1:0] edge_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= EDGE_COUNT_BITS'(EDGE_COUNT_RESET);
      end else if (psel && penable && pwrite && paddr == CSR_ADDR_EDGE_COUNT) begin
         edge_count_ff <= pwdata[EDGE_COUNT_BITS-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_ADDR_EDGE_COUNT) ?
                   CSR_DATA_BITS'(edge_count_ff) : '0;

   // ---------------- state and control ----------------
   state_type state_ff, state_in;

   logic req_ready_c, div_start_c, t_update_c, edge_next_c, rsp_load_c;
   logic load_accept, clip_accept;

   logic [KW-1:0]       k_ff, i_ff, j_c, k_sat;
   logic signed [C-1:0] p1x_ff, p1y_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [F:0]          te_ff, tl_ff;
   logic                reject_ff;

   logic signed [C-1:0] mem_x [MAX_VERTICES];
   logic signed [C-1:0] mem_y [MAX_VERTICES];
   logic signed [C-1:0] xi_ff, yi_ff, xj_ff, yj_ff;
   logic [IW-1:0]       load_idx;

   logic signed [MW-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [PW-1:0] num_ff, den_ff;
   logic signed [PW-1:0] a_c, b_c;
   logic                 den_zero, den_pos, reject_c, edge_last;
   logic [F:0]           t_c;

   logic          div_done;
   logic [F-1:0]  div_q;

   logic signed [LW-1:0] lsx_ff, lsy_ff, lex_ff, ley_ff;

   logic                 rsp_valid_ff;
   logic                 vis_ff;
   logic [F:0]           ent_ff, ext_ff;
   logic signed [C-1:0]  csx_ff, csy_ff, cex_ff, cey_ff;

   assign load_accept = req.valid && req_ready_c && req.func == FUNC_LOAD;
   assign clip_accept = req.valid && req_ready_c && req.func == FUNC_CLIP;

   always_comb begin
      k_sat = KW'(edge_count_ff);
      if (k_sat < KW'(EDGE_COUNT_MIN)) begin
         k_sat = KW'(EDGE_COUNT_MIN);
      end else if (k_sat > KW'(MAX_VERTICES)) begin
         k_sat = KW'(MAX_VERTICES);
      end
   end

   assign j_c       = (i_ff + KW'(1) == k_ff) ? '0 : i_ff + KW'(1);
   assign edge_last = (i_ff + KW'(1) == k_ff);

   // edge evaluation
   always_comb begin
      den_zero = (den_ff == '0);
      den_pos  = !den_zero && !den_ff[PW-1];
      a_c      = den_pos ? -num_ff : num_ff;
      b_c      = den_pos ? den_ff : -den_ff;
      reject_c = den_zero && num_ff[PW-1];
      if (state_ff == ST_DIV) begin
         t_c = {1'b0, div_q};
      end else if (a_c <= 0) begin
         t_c = '0;
      end else begin
         t_c = T_ONE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (clip_accept) state_in = ST_READ;
         ST_READ: state_in = ST_MULT;
         ST_MULT: state_in = ST_SUM;
         ST_SUM:  state_in = ST_EVAL;
         ST_EVAL: begin
            if (!den_zero && a_c > 0 && a_c < b_c) begin
               state_in = ST_DIV;
            end else if (reject_c || edge_last) begin
               state_in = ST_LERP;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = edge_last ? ST_LERP : ST_READ;
            end
         end
         ST_LERP: state_in = ST_OUT;
         ST_OUT:  if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready_c = 1'b0;
      div_start_c = 1'b0;
      t_update_c  = 1'b0;
      edge_next_c = 1'b0;
      rsp_load_c  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready_c = 1'b1;
         ST_EVAL: begin
            if (!den_zero && a_c > 0 && a_c < b_c) begin
               div_start_c = 1'b1;
            end else begin
               t_update_c  = !den_zero;
               edge_next_c = 1'b1;
            end
         end
         ST_DIV: begin
            t_update_c  = div_done;
            edge_next_c = div_done;
         end
         ST_OUT:  rsp_load_c = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   assign req.ready = req_ready_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- vertex memory ----------------
   assign load_idx = IW'(req.vertex_index);

   always_ff @(posedge clock) begin
      if (load_accept && (IW+1)'(load_idx) < (IW+1)'(MAX_VERTICES)) begin
         mem_x[load_idx[AW-1:0]] <= req.vertex_x;
         mem_y[load_idx[AW-1:0]] <= req.vertex_y;
      end
      xi_ff <= mem_x[i_ff[AW-1:0]];
      yi_ff <= mem_y[i_ff[AW-1:0]];
      xj_ff <= mem_x[j_c[AW-1:0]];
      yj_ff <= mem_y[j_c[AW-1:0]];
   end

   // ---------------- per-edge datapath ----------------
   logic signed [DW-1:0] nx_c, ny_c, wx_c, wy_c;

   always_comb begin
      nx_c = DW'(yi_ff) - DW'(yj_ff);
      ny_c = DW'(xj_ff) - DW'(xi_ff);
      wx_c = DW'(p1x_ff) - DW'(xi_ff);
      wy_c = DW'(p1y_ff) - DW'(yi_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MULT) begin
         pa_ff <= MW'(nx_c) * MW'(wx_c);
         pb_ff <= MW'(ny_c) * MW'(wy_c);
         pc_ff <= MW'(nx_c) * MW'(dx_ff);
         pd_ff <= MW'(ny_c) * MW'(dy_ff);
      end
      if (state_ff == ST_SUM) begin
         num_ff <= PW'(pa_ff) + PW'(pb_ff);
         den_ff <= PW'(pc_ff) + PW'(pd_ff);
      end
   end

   cplc_div_chain #(.UW(PW), .QW(F)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_c),
      .dividend (a_c),
      .divisor  (b_c),
      .done     (div_done),
      .quotient (div_q)
   );

   // clip item registers
   always_ff @(posedge clock) begin
      if (clip_accept) begin
         p1x_ff    <= req.start_x;
         p1y_ff    <= req.start_y;
         dx_ff     <= DW'(req.end_x) - DW'(req.start_x);
         dy_ff     <= DW'(req.end_y) - DW'(req.start_y);
         k_ff      <= k_sat;
         i_ff      <= '0;
         te_ff     <= '0;
         tl_ff     <= T_ONE;
         reject_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EVAL && reject_c) begin
            reject_ff <= 1'b1;
         end
         if (t_update_c) begin
            // den sign is still held from the sum stage
            if (den_pos) begin
               if (t_c > te_ff) te_ff <= t_c;
            end else begin
               if (t_c < tl_ff) tl_ff <= t_c;
            end
         end
         if (edge_next_c && !edge_last) begin
            i_ff <= i_ff + KW'(1);
         end
      end
   end

   // ---------------- endpoint interpolation ----------------
   function automatic logic signed [C-1:0] lerp_off(input logic signed [LW-1:0] prod);
      logic [LW-1:0] mag;
      logic [LW-1:0] sh;
      mag = prod[LW-1] ? LW'(-prod) : LW'(prod);
      sh  = mag >> F;
      return prod[LW-1] ? -C'(sh) : C'(sh);
   endfunction

   always_ff @(posedge clock) begin
      if (state_ff == ST_LERP) begin
         lsx_ff <= LW'(dx_ff) * LW'({1'b0, te_ff});
         lsy_ff <= LW'(dy_ff) * LW'({1'b0, te_ff});
         lex_ff <= LW'(dx_ff) * LW'({1'b0, tl_ff});
         ley_ff <= LW'(dy_ff) * LW'({1'b0, tl_ff});
      end
   end

   // ---------------- response register ----------------
   logic vis_c;
   assign vis_c = !reject_ff && (te_ff < tl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load_c) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load_c) begin
         vis_ff <= vis_c;
         ent_ff <= vis_c ? te_ff : '0;
         ext_ff <= vis_c ? tl_ff : '0;
         csx_ff <= vis_c ? p1x_ff + lerp_off(lsx_ff) : '0;
         csy_ff <= vis_c ? p1y_ff + lerp_off(lsy_ff) : '0;
         cex_ff <= vis_c ? p1x_ff + lerp_off(lex_ff) : '0;
         cey_ff <= vis_c ? p1y_ff + lerp_off(ley_ff) : '0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.visible      = vis_ff;
   assign rsp.enter_t      = ent_ff;
   assign rsp.exit_t       = ext_ff;
   assign rsp.clip_start_x = csx_ff;
   assign rsp.clip_start_y = csy_ff;
   assign rsp.clip_end_x   = cex_ff;
   assign rsp.clip_end_y   = cey_ff;
endmodule

@@ design/cplc_checker.sv @@
// ----------------------------------------------------------------------------
// cplc_checker
// Port-level checks on the line clipper response channel.
// ----------------------------------------------------------------------------
module cplc_checker #(
   parameter int COORD_BITS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_visible,
   input logic [T_FRAC_BITS:0] rsp_enter_t,
   input logic [T_FRAC_BITS:0] rsp_exit_t
);
   localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_exit_t))
      else $error("stalled response dropped or changed");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_enter_t == 0 && rsp_exit_t == 0)
      else $error("invisible item carries nonzero t");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_visible |-> rsp_enter_t < rsp_exit_t && rsp_exit_t <= T_ONE)
      else $error("visible item with bad t range");
endmodule

bind convex_polygon_line_clipper cplc_checker #(
   .COORD_BITS  (COORD_BITS),
   .T_FRAC_BITS (T_FRAC_BITS)
) u_cplc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_visible (rsp.visible),
   .rsp_enter_t (rsp.enter_t),
   .rsp_exit_t  (rsp.exit_t)
);
